@@ sv/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants for the XOR base64url decoder
// Character classes, symbol lookup and the result record passed to the top.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

	localparam logic [7:0] XOR_KEY_RESET = 8'd11;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_PAD     = 8'h3D;
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;

	typedef enum logic [1:0] {
		CLS_SPACE,
		CLS_STOP,
		CLS_SYMBOL,
		CLS_BAD
	} char_class_t;

	typedef struct packed {
		char_class_t cls;
		logic [5:0]  sextet;
	} char_info_t;

	typedef struct packed {
		logic       emit;
		logic [7:0] out_byte;
		logic       has_byte;
		logic       bad_char;
		logic       end_of_message;
	} b64d_result_t;

	function automatic char_info_t classify(input logic [7:0] c);
		char_info_t info;
		info.cls    = CLS_BAD;
		info.sextet = 6'd0;
		if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) begin
			info.cls = CLS_SPACE;
		end else if (c == CH_PAD || c == CH_NUL) begin
			info.cls = CLS_STOP;
		end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			info.cls    = CLS_SYMBOL;
			info.sextet = 6'(c - CH_UPPER_A);
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			info.cls    = CLS_SYMBOL;
			info.sextet = 6'(c - CH_LOWER_A + 8'd26);
		end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
			info.cls    = CLS_SYMBOL;
			info.sextet = 6'(c - CH_DIGIT_0 + 8'd52);
		end else if (c == CH_MINUS) begin
			info.cls    = CLS_SYMBOL;
			info.sextet = 6'd62;
		end else if (c == CH_UNDER) begin
			info.cls    = CLS_SYMBOL;
			info.sextet = 6'd63;
		end
		return info;
	endfunction

endpackage

`default_nettype wire

@@ sv/b64d_core.sv @@
// ----------------------------------------------------------------------------
// b64d_core: per-message decode state and next-result logic
// Classifies one key-mixed byte, updates the bit accumulator and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_core
	import b64d_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         fire,
	input  wire logic [7:0]   item_byte,
	input  wire logic         item_last,
	input  wire logic [7:0]   xor_key,
	output b64d_result_t      result
);

	logic [11:0] bit_store_q;
	logic [2:0]  bit_count_q;
	logic        stopped_q;
	logic        error_q;

	logic [11:0] store_nxt;
	logic [2:0]  count_nxt;
	logic        stopped_nxt;
	logic        error_nxt;
	logic [11:0] shifted;
	logic [7:0]  dec_byte;
	logic        has;
	logic        emit;
	char_info_t  info;

	always_comb begin
		info        = classify(item_byte ^ xor_key);
		shifted     = {bit_store_q[5:0], info.sextet};
		store_nxt   = bit_store_q;
		count_nxt   = bit_count_q;
		stopped_nxt = stopped_q;
		error_nxt   = error_q;
		has         = 1'b0;
		emit        = 1'b0;
		dec_byte    = 8'd0;
		if (!stopped_q && !error_q) begin
			case (info.cls)
				CLS_SPACE: begin
				end
				CLS_STOP: begin
					stopped_nxt = 1'b1;
				end
				CLS_SYMBOL: begin
					store_nxt = shifted;
					case (bit_count_q)
						3'd2: begin
							dec_byte  = shifted[7:0];
							has       = 1'b1;
							count_nxt = 3'd0;
						end
						3'd4: begin
							dec_byte  = shifted[9:2];
							has       = 1'b1;
							count_nxt = 3'd2;
						end
						3'd6: begin
							dec_byte  = shifted[11:4];
							has       = 1'b1;
							count_nxt = 3'd4;
						end
						default: begin
							count_nxt = 3'd6;
						end
					endcase
					emit = has;
				end
				default: begin
					error_nxt = 1'b1;
					emit      = 1'b1;
				end
			endcase
		end
		result.emit           = emit || item_last;
		result.out_byte       = dec_byte;
		result.has_byte       = has;
		result.bad_char       = error_nxt;
		result.end_of_message = item_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_store_q <= 12'd0;
			bit_count_q <= 3'd0;
			stopped_q   <= 1'b0;
			error_q     <= 1'b0;
		end else if (fire) begin
			if (item_last) begin
				bit_store_q <= 12'd0;
				bit_count_q <= 3'd0;
				stopped_q   <= 1'b0;
				error_q     <= 1'b0;
			end else begin
				bit_store_q <= store_nxt;
				bit_count_q <= count_nxt;
				stopped_q   <= stopped_nxt;
				error_q     <= error_nxt;
			end
		end
	end

	a_count_even: assert property (@(posedge clk) disable iff (!arst_n)
		!bit_count_q[0])
		else $error("bit count is odd");

	a_stop_err_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(stopped_q && error_q))
		else $error("stop and error both set");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_last |=> bit_count_q == 3'd0 && !stopped_q && !error_q)
		else $error("state not cleared after end of message");

	a_byte_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		fire && result.has_byte |=> !error_q)
		else $error("decoded byte together with error");

endmodule

`default_nettype wire

@@ sv/xor_base64url_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// xor_base64url_stream_decoder: key-mixed URL-safe base64 stream decoder
// Input bytes are XORed with a key and decoded; one result per decoded byte,
// per first invalid character, and per end of message (one result where they coincide).
//
// Usage:
//   s_axis carries one raw byte per transaction in tdata, message end in
//   tlast. m_axis carries the decoded byte in tdata, has_byte and bad_char in
//   tuser, and end_of_message in tlast. Bytes that cause no result (padding,
//   whitespace, partial sextets, anything after a stop or error) are consumed
//   silently. cfg_we/cfg_wdata load xor_key; write it only while idle.
//   Path: an accepted transaction loads the input register; its result is
//   registered from the decode stage once m_axis is free, and drives m_axis.
//   Throughput: one input transaction per cycle while m_axis is ready; the
//   single decode stage between the two registers sets this.
//   When m_axis stalls with a result held, the input register still accepts
//   one more transaction, then s_axis_tready drops until the result drains.
//   Reset clears the decode state and the valid flags of both registers and loads xor_key = 11.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_base64url_stream_decoder
	import b64d_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  wire logic       s_axis_tlast,
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
	output logic [1:0]      m_axis_tuser,   // [0] has_byte, [1] bad_char
	output logic            m_axis_tlast
);

	logic [7:0]   xor_key_q;
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         out_free;
	logic         fire;
	b64d_result_t result;

	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign fire          = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_key_q <= XOR_KEY_RESET;
		end else if (cfg_we) begin
			xor_key_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	b64d_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item_byte (byte_s1),
		.item_last (last_s1),
		.xor_key   (xor_key_q),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_free) begin
			m_axis_tvalid <= fire && result.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && result.emit) begin
			m_axis_tdata <= result.out_byte;
			m_axis_tuser <= {result.bad_char, result.has_byte};
			m_axis_tlast <= result.end_of_message;
		end
	end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for xor_base64url_stream_decoder
// A directed run through the character classes under the reset key, short
// messages under the extreme keys, then random messages (mostly well-formed
// base64url text, some broken or noisy) under changing keys. A bit-level
// decoder in the bench predicts every result and a scoreboard checks the
// m_axis stream field by field. Sender gaps, receiver stalls and one long
// receiver hold-off push the block through its stall paths.
// ----------------------------------------------------------------------------

module tb;
	import b64d_pkg::*;

	localparam int CLK_HALF_NS   = 4;
	localparam int RESET_CYCLES  = 9;
	localparam int RANDOM_ITEMS  = 1560;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       bad;
		logic       eom;
	} dec_result_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_PATTERN,
		RX_RANDOM
	} rx_mode_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;   // [7:0] in_byte
	logic       s_axis_tlast;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;   // [7:0] out_byte
	logic [1:0] m_axis_tuser;   // [0] has_byte, [1] bad_char
	logic       m_axis_tlast;

	xor_base64url_stream_decoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// decoder state mirrored by the bench
	logic [7:0]  dec_key;
	logic [11:0] dec_bits;
	logic [2:0]  dec_held;
	logic        dec_stopped;
	logic        dec_error;

	dec_result_t pending_results[$];
	logic [7:0]  msg_buf[$];

	int       tx_burst_left;
	int       tx_gap_max;
	rx_mode_t rx_mode;
	logic [15:0] rx_pattern;
	int       rx_tick;
	int       hold_req;
	int       hold_left;

	int cycles;
	int fails;
	int items_sent;
	int live_items;
	int msgs_sent;
	int keys_written;
	int results_seen;
	int bytes_seen;
	int bad_seen;

	always begin
		clk = 1'b1;
		#CLK_HALF_NS;
		clk = 1'b0;
		#CLK_HALF_NS;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic char_class_t char_kind(input logic [7:0] c, output logic [5:0] v);
		v = '0;
		if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE)
			return CLS_SPACE;
		if (c == CH_PAD || c == CH_NUL)
			return CLS_STOP;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			v = 6'(c - CH_UPPER_A);
			return CLS_SYMBOL;
		end
		if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			v = 6'(c - CH_LOWER_A) + 6'd26;
			return CLS_SYMBOL;
		end
		if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
			v = 6'(c - CH_DIGIT_0) + 6'd52;
			return CLS_SYMBOL;
		end
		if (c == CH_MINUS) begin
			v = 6'd62;
			return CLS_SYMBOL;
		end
		if (c == CH_UNDER) begin
			v = 6'd63;
			return CLS_SYMBOL;
		end
		return CLS_BAD;
	endfunction

	function automatic logic [7:0] symbol_char(input logic [5:0] v);
		if (v < 6'd26)
			return CH_UPPER_A + 8'(v);
		if (v < 6'd52)
			return CH_LOWER_A + 8'(v) - 8'd26;
		if (v < 6'd62)
			return CH_DIGIT_0 + 8'(v) - 8'd52;
		if (v == 6'd62)
			return CH_MINUS;
		return CH_UNDER;
	endfunction

	function automatic logic [7:0] space_char();
		int k;
		k = $urandom_range(0, 5);
		return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
	endfunction

	task automatic clear_decoder();
		dec_bits    = '0;
		dec_held    = '0;
		dec_stopped = 1'b0;
		dec_error   = 1'b0;
	endtask

	// advance the mirrored decoder by one accepted byte and queue its result, if it has one
	task automatic decode_byte(input logic [7:0] raw, input logic last);
		logic [7:0]  c;
		logic [5:0]  v;
		logic [3:0]  n;
		char_class_t k;
		dec_result_t r;
		logic        emit;
		c    = raw ^ dec_key;
		r    = '0;
		emit = 1'b0;
		if (!dec_stopped && !dec_error) begin
			live_items++;
			k = char_kind(c, v);
			case (k)
				CLS_SPACE: begin
				end
				CLS_STOP: begin
					dec_stopped = 1'b1;
				end
				CLS_BAD: begin
					dec_error = 1'b1;
					emit      = 1'b1;
				end
				default: begin
					dec_bits = {dec_bits[5:0], v};
					n        = {1'b0, dec_held} + 4'd6;
					if (n >= 4'd8) begin
						n      = n - 4'd8;
						r.data = 8'(dec_bits >> n);
						r.has  = 1'b1;
						emit   = 1'b1;
					end
					dec_held = n[2:0];
				end
			endcase
		end
		if (last)
			emit = 1'b1;
		if (emit) begin
			r.bad = dec_error;
			r.eom = last;
			pending_results = {pending_results, r};
		end
		if (last) begin
			clear_decoder();
			msgs_sent++;
		end
	endtask

	task automatic send_byte(input logic [7:0] raw, input logic last);
		int gap;
		if (tx_burst_left == 0) begin
			gap = $urandom_range(0, tx_gap_max);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			tx_burst_left = $urandom_range(1, 24);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= raw;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		decode_byte(raw, last);
		tx_burst_left--;
		items_sent++;
	endtask

	task automatic send_char(input logic [7:0] c, input logic last);
		send_byte(c ^ dec_key, last);
	endtask

	task automatic send_text(input string s, input logic end_msg);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], end_msg && (i == s.len() - 1));
	endtask

	task automatic send_message();
		for (int i = 0; i < msg_buf.size(); i++)
			send_char(msg_buf[i], i == msg_buf.size() - 1);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_key(input logic [7:0] k);
		cfg_we    <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_we  <= 1'b0;
		dec_key = k;
		keys_written++;
	endtask

	// mostly well-formed text; some with a bad character, some noise, some NUL stops
	task automatic build_message();
		int         kind;
		int         n;
		int         pos;
		logic [7:0] c;
		logic [5:0] v;
		msg_buf.delete();
		kind = $urandom_range(0, 9);
		if (kind == 8) begin
			n = $urandom_range(1, 8);
			repeat (n) msg_buf = {msg_buf, 8'($urandom)};
		end else begin
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : $urandom_range(4, 24);
			repeat (n) begin
				if ($urandom_range(0, 9) == 0)
					msg_buf = {msg_buf, space_char()};
				msg_buf = {msg_buf, symbol_char(6'($urandom))};
			end
			if (kind == 9) begin
				msg_buf = {msg_buf, CH_NUL};
				repeat ($urandom_range(0, 3)) msg_buf = {msg_buf, 8'($urandom)};
			end else begin
				repeat ($urandom_range(0, 2)) msg_buf = {msg_buf, CH_PAD};
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3)) msg_buf = {msg_buf, 8'($urandom)};
			end
			if (kind == 6 || kind == 7) begin
				do
					c = 8'($urandom);
				while (char_kind(c, v) != CLS_BAD);
				pos = $urandom_range(0, msg_buf.size());
				msg_buf.insert(pos, c);
			end
		end
		if (msg_buf.size() == 0)
			msg_buf = {msg_buf, space_char()};
	endtask

	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		rx_tick++;
		if (rx_tick % 64 == 0)
			rx_pattern <= 16'($urandom) | 16'h0001;
		else
			rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_OPEN:    m_axis_tready <= 1'b1;
				RX_PATTERN: m_axis_tready <= rx_pattern[0];
				default:    m_axis_tready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		dec_result_t got;
		dec_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast};
			results_seen++;
			if (pending_results.size() == 0) begin
				fails++;
				if (fails <= REPORT_LIMIT)
					$display("%0t: result with nothing expected: data %02h has %b bad %b eom %b",
						$realtime, got.data, got.has, got.bad, got.eom);
			end else begin
				want = pending_results.pop_front();
				if (got.data !== want.data || got.has !== want.has ||
				    got.bad !== want.bad || got.eom !== want.eom) begin
					fails++;
					if (fails <= REPORT_LIMIT)
						$display("%0t: expected data %02h has %b bad %b eom %b, got data %02h has %b bad %b eom %b",
							$realtime, want.data, want.has, want.bad, want.eom,
							got.data, got.has, got.bad, got.eom);
				end
				if (want.has)
					bytes_seen++;
				if (want.bad)
					bad_seen++;
			end
		end
	end

	task automatic test_reset_key();
		tx_gap_max = 0;
		rx_mode    = RX_OPEN;
		send_text("TWFu", 1'b1);
		send_text(" \t\r-_=A", 1'b1);
		send_text("Zz9", 1'b0);
		send_char(CH_NUL, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_char("a", 1'b0);
		send_byte(8'hFF, 1'b0);
		send_text("bc", 1'b1);
		send_text("Q", 1'b1);
	endtask

	task automatic test_key_extremes();
		wait_idle();
		write_key(8'h00);
		send_text("Zm", 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		wait_idle();
		write_key(8'hFF);
		send_byte(8'h00, 1'b0);
		send_text("-A", 1'b1);
	endtask

	task automatic test_random_messages();
		int start;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0) begin
				wait_idle();
				case ($urandom_range(0, 3))
					0:       write_key(8'h00);
					1:       write_key(8'hFF);
					2:       write_key(XOR_KEY_RESET);
					default: write_key(8'($urandom));
				endcase
			end
			case ($urandom_range(0, 3))
				0:       tx_gap_max = 0;
				1:       tx_gap_max = 1;
				2:       tx_gap_max = 4;
				default: tx_gap_max = 10;
			endcase
			case ($urandom_range(0, 2))
				0:       rx_mode = RX_OPEN;
				1:       rx_mode = RX_PATTERN;
				default: rx_mode = RX_RANDOM;
			endcase
			build_message();
			send_message();
		end
	endtask

	// hold the receiver off while the sender keeps offering transactions
	task automatic test_backpressure();
		wait_idle();
		write_key(8'($urandom));
		tx_gap_max = 0;
		rx_mode    = RX_OPEN;
		hold_req   = HOLD_CYCLES;
		repeat (4) begin
			build_message();
			send_message();
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		rx_mode       = RX_OPEN;
		rx_pattern    = 16'hA5C3;
		rx_tick       = 0;
		hold_req      = 0;
		hold_left     = 0;
		tx_burst_left = 0;
		tx_gap_max    = 0;
		cycles        = 0;
		fails         = 0;
		items_sent    = 0;
		live_items    = 0;
		msgs_sent     = 0;
		keys_written  = 0;
		results_seen  = 0;
		bytes_seen    = 0;
		bad_seen      = 0;
		dec_key       = XOR_KEY_RESET;
		clear_decoder();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_key();
		test_key_extremes();
		test_random_messages();
		test_backpressure();

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d messages, %0d input transactions (%0d decoded), %0d key writes",
			msgs_sent, items_sent, live_items, keys_written);
		$display("checked %0d results: %0d bytes, %0d flagged bad_char, %0d mismatches",
			results_seen, bytes_seen, bad_seen, fails);
		if (fails == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
